@@ hdl/tcw_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int X_W        = 7;
  localparam int Y_W        = 5;
  localparam int POS_W      = 11;
  localparam int TAB_BLANKS = 4;
  localparam int TAB_W      = $clog2(TAB_BLANKS + 1);

  localparam logic [7:0] RESET_COLOR = 8'd15;
  localparam logic [7:0] CH_BLANK    = 8'd32;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_TAB      = 8'd9;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_MOVE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUT_CHAR,
    OP_PUT_BLANK,
    OP_RETURN,
    OP_NEWLINE,
    OP_MOVE,
    OP_READ,
    OP_HOME,
    OP_FILL,
    OP_COPY
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   latch;
    logic   cnt_clr;
    logic   fill_rst;
    logic   scr_set;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic line_end;
    logic bottom;
    logic copy_last;
    logic fill_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/tcw_ctrl.sv @@
// Sequencing state machine for the text console writer.
`default_nettype none

module tcw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         char_code_i,
  output logic               in_stall_o,
  output tcw_pkg::dp_cmd_t   dp_cmd_o,
  input  tcw_pkg::dp_stat_t  dp_stat_i
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TAB   = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_SFILL = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [TAB_W-1:0] tab_q, tab_d;
  logic             accept;
  logic             wrap_scroll;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign wrap_scroll = dp_stat_i.line_end && dp_stat_i.bottom;

  always_comb begin
    state_d  = state_q;
    tab_d    = tab_q;
    dp_cmd_o = '0;
    unique case (state_q)
      S_INIT: begin
        dp_cmd_o.op       = OP_FILL;
        dp_cmd_o.fill_rst = 1'b1;
        if (dp_stat_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          dp_cmd_o.latch = 1'b1;
          tab_d          = '0;
          unique case (cmd_i)
            CMD_PUT: begin
              priority if (char_code_i == CH_CR) begin
                dp_cmd_o.op = OP_RETURN;
                state_d     = S_FIN;
              end else if (char_code_i == CH_LF) begin
                dp_cmd_o.op = OP_NEWLINE;
                if (dp_stat_i.bottom) begin
                  dp_cmd_o.scr_set = 1'b1;
                  dp_cmd_o.cnt_clr = 1'b1;
                  state_d          = S_COPY;
                end else begin
                  state_d = S_FIN;
                end
              end else if (char_code_i == CH_TAB) begin
                tab_d   = TAB_W'(TAB_BLANKS);
                state_d = S_TAB;
              end else begin
                dp_cmd_o.op = OP_PUT_CHAR;
                if (wrap_scroll) begin
                  dp_cmd_o.scr_set = 1'b1;
                  dp_cmd_o.cnt_clr = 1'b1;
                  state_d          = S_COPY;
                end else begin
                  state_d = S_FIN;
                end
              end
            end
            CMD_MOVE: begin
              dp_cmd_o.op = OP_MOVE;
              state_d     = S_FIN;
            end
            CMD_CLEAR: begin
              dp_cmd_o.op      = OP_HOME;
              dp_cmd_o.cnt_clr = 1'b1;
              state_d          = S_CLEAR;
            end
            CMD_READ: begin
              dp_cmd_o.op = OP_READ;
              state_d     = S_FIN;
            end
          endcase
        end
      end
      S_TAB: begin
        dp_cmd_o.op = OP_PUT_BLANK;
        tab_d       = tab_q - TAB_W'(1);
        if (wrap_scroll) begin
          dp_cmd_o.scr_set = 1'b1;
          dp_cmd_o.cnt_clr = 1'b1;
          state_d          = S_COPY;
        end else if (tab_q == TAB_W'(1)) begin
          state_d = S_FIN;
        end
      end
      S_COPY: begin
        dp_cmd_o.op = OP_COPY;
        if (dp_stat_i.copy_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_SFILL;
      end
      S_SFILL: begin
        dp_cmd_o.op = OP_FILL;
        if (dp_stat_i.fill_last) begin
          state_d = (tab_q != '0) ? S_TAB : S_FIN;
        end
      end
      S_CLEAR: begin
        dp_cmd_o.op = OP_FILL;
        if (dp_stat_i.fill_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (dp_stat_i.out_free) begin
          dp_cmd_o.out_load = 1'b1;
          state_d           = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      tab_q   <= '0;
    end else begin
      state_q <= state_d;
      tab_q   <= tab_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tcw_datapath.sv @@
// Screen store, cursor, sweep counter, colour register and result register.
`default_nettype none

module tcw_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                cmd_i,
  input  logic [7:0]                char_code_i,
  input  logic [7:0]                col_i,
  input  logic [7:0]                row_i,
  input  logic                      cfg_we_i,
  input  logic [7:0]                cfg_wdata_i,
  input  tcw_pkg::dp_cmd_t          dp_cmd_i,
  output tcw_pkg::dp_stat_t         dp_stat_o,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [tcw_pkg::X_W-1:0]   cursor_col_o,
  output logic [tcw_pkg::Y_W-1:0]   cursor_row_o,
  output logic [tcw_pkg::POS_W-1:0] cursor_pos_o,
  output logic [7:0]                read_char_o,
  output logic [7:0]                read_color_o,
  output logic                      scrolled_o
);
  import tcw_pkg::*;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata_q;
  logic              we, re;
  logic [CELL_W-1:0] waddr, raddr;
  logic [15:0]       wdata;

  logic [7:0]        color_q;
  logic [X_W-1:0]    cx_q, cx_d, col_cl;
  logic [Y_W-1:0]    cy_q, cy_d, row_cl;
  logic [CELL_W-1:0] cnt_q, cnt_d;
  logic [CELL_W-1:0] cur_idx, rd_idx;
  logic              copy_v_q;
  logic [CELL_W-1:0] copy_addr_q;
  logic              scr_q, is_read_q;
  logic              out_valid_q;
  logic [7:0]        fill_color;

  assign col_cl = (col_i > 8'(COLUMNS - 1)) ? X_W'(COLUMNS - 1) : col_i[X_W-1:0];
  assign row_cl = (row_i > 8'(ROWS - 1)) ? Y_W'(ROWS - 1) : row_i[Y_W-1:0];

  assign cur_idx = CELL_W'(cy_q) * CELL_W'(COLUMNS) + CELL_W'(cx_q);
  assign rd_idx  = CELL_W'(row_cl) * CELL_W'(COLUMNS) + CELL_W'(col_cl);

  assign dp_stat_o.line_end  = (cx_q == X_W'(COLUMNS - 1));
  assign dp_stat_o.bottom    = (cy_q == Y_W'(ROWS - 1));
  assign dp_stat_o.copy_last = (cnt_q == CELL_W'(CELLS - COLUMNS - 1));
  assign dp_stat_o.fill_last = (cnt_q == CELL_W'(CELLS - 1));
  assign dp_stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign fill_color = dp_cmd_i.fill_rst ? RESET_COLOR : color_q;

  // write port: delayed copy write, cell put, or blank fill
  always_comb begin
    we    = 1'b0;
    waddr = cur_idx;
    wdata = {color_q, char_code_i};
    priority if (copy_v_q) begin
      we    = 1'b1;
      waddr = copy_addr_q;
      wdata = rdata_q;
    end else if (dp_cmd_i.op == OP_PUT_CHAR) begin
      we = 1'b1;
    end else if (dp_cmd_i.op == OP_PUT_BLANK) begin
      we    = 1'b1;
      wdata = {color_q, CH_BLANK};
    end else if (dp_cmd_i.op == OP_FILL) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = {fill_color, CH_BLANK};
    end else begin
      we = 1'b0;
    end
  end

  assign re    = (dp_cmd_i.op == OP_READ) || (dp_cmd_i.op == OP_COPY);
  assign raddr = (dp_cmd_i.op == OP_READ) ? rd_idx : cnt_q + CELL_W'(COLUMNS);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    unique case (dp_cmd_i.op)
      OP_PUT_CHAR, OP_PUT_BLANK: begin
        if (dp_stat_o.line_end) begin
          cx_d = '0;
          if (!dp_stat_o.bottom) begin
            cy_d = cy_q + Y_W'(1);
          end
        end else begin
          cx_d = cx_q + X_W'(1);
        end
      end
      OP_RETURN: begin
        cx_d = '0;
      end
      OP_NEWLINE: begin
        cx_d = '0;
        if (!dp_stat_o.bottom) begin
          cy_d = cy_q + Y_W'(1);
        end
      end
      OP_MOVE: begin
        cx_d = col_cl;
        cy_d = row_cl;
      end
      OP_HOME: begin
        cx_d = '0;
        cy_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    priority if (dp_cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (dp_cmd_i.op == OP_FILL || dp_cmd_i.op == OP_COPY) begin
      cnt_d = cnt_q + CELL_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= RESET_COLOR;
      cx_q        <= '0;
      cy_q        <= '0;
      cnt_q       <= '0;
      copy_v_q    <= 1'b0;
      scr_q       <= 1'b0;
      is_read_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      cnt_q    <= cnt_d;
      copy_v_q <= (dp_cmd_i.op == OP_COPY);
      if (dp_cmd_i.scr_set) begin
        scr_q <= 1'b1;
      end else if (dp_cmd_i.latch) begin
        scr_q <= 1'b0;
      end
      if (dp_cmd_i.latch) begin
        is_read_q <= (cmd_i == CMD_READ);
      end
      if (dp_cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    copy_addr_q <= cnt_q;
    if (dp_cmd_i.out_load) begin
      cursor_col_o <= cx_q;
      cursor_row_o <= cy_q;
      cursor_pos_o <= POS_W'(cy_q) * POS_W'(COLUMNS) + POS_W'(cx_q);
      read_char_o  <= is_read_q ? rdata_q[7:0] : 8'd0;
      read_color_o <= is_read_q ? rdata_q[15:8] : 8'd0;
      scrolled_o   <= scr_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/text_console_writer_core.sv @@
// Top level of the text console writer: controller plus datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_stall_o | cmd_i, char_code_i, col_i, row_i
//  out     | output    | out_valid_o/out_stall_i | cursor_col_o, cursor_row_o, cursor_pos_o,
//          |           |                      | read_char_o, read_color_o, scrolled_o
//  cfg     | input     | cfg_we_i             | cfg_wdata_i (text colour)
//
// A scroll copies one cell per cycle over the single write port of the screen store,
// then fills the bottom row; clear likewise sweeps every cell, one per cycle.
// After reset the screen store is cleared before the first transaction is taken.
// The result register frees the input side while a result waits on out_stall_i.
`default_nettype none

module text_console_writer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                cmd_i,
  input  logic [7:0]                char_code_i,
  input  logic [7:0]                col_i,
  input  logic [7:0]                row_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [tcw_pkg::X_W-1:0]   cursor_col_o,
  output logic [tcw_pkg::Y_W-1:0]   cursor_row_o,
  output logic [tcw_pkg::POS_W-1:0] cursor_pos_o,
  output logic [7:0]                read_char_o,
  output logic [7:0]                read_color_o,
  output logic                      scrolled_o,
  input  logic                      cfg_we_i,
  input  logic [7:0]                cfg_wdata_i
);
  import tcw_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .char_code_i (char_code_i),
    .in_stall_o  (in_stall_o),
    .dp_cmd_o    (dp_cmd),
    .dp_stat_i   (dp_stat)
  );

  tcw_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .char_code_i  (char_code_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .dp_cmd_i     (dp_cmd),
    .dp_stat_o    (dp_stat),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cursor_pos_o (cursor_pos_o),
    .read_char_o  (read_char_o),
    .read_color_o (read_color_o),
    .scrolled_o   (scrolled_o)
  );

endmodule

`default_nettype wire

@@ hdl/tcw_checker.sv @@
// Port-level assertions for the text console writer, bound to the top level.
`default_nettype none

module tcw_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [tcw_pkg::X_W-1:0]   cursor_col_o,
  input logic [tcw_pkg::Y_W-1:0]   cursor_row_o,
  input logic [tcw_pkg::POS_W-1:0] cursor_pos_o,
  input logic                      scrolled_o
);
  import tcw_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on consecutive cycles");

  a_pos_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cursor_pos_o == POS_W'(cursor_row_o * COLUMNS + cursor_col_o))
    else $error("cursor position disagrees with row and column");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_col_o <= X_W'(COLUMNS - 1)) && (cursor_row_o <= Y_W'(ROWS - 1)))
    else $error("cursor outside the screen");

  a_scroll_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> cursor_row_o == Y_W'(ROWS - 1))
    else $error("scroll reported off the bottom row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cursor_pos_o))
    else $error("stalled result changed");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the text console writer core: directed and random transactions.
`default_nettype none

module testbench;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [7:0] col;
    logic [7:0] row;
  } console_cmd_t;

  typedef struct packed {
    logic [X_W-1:0]   col;
    logic [Y_W-1:0]   row;
    logic [POS_W-1:0] pos;
    logic [7:0]       ch;
    logic [7:0]       color;
    logic             scrolled;
  } console_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       cmd_i;
  logic [7:0]       char_code_i;
  logic [7:0]       col_i;
  logic [7:0]       row_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [X_W-1:0]   cursor_col_o;
  logic [Y_W-1:0]   cursor_row_o;
  logic [POS_W-1:0] cursor_pos_o;
  logic [7:0]       read_char_o;
  logic [7:0]       read_color_o;
  logic             scrolled_o;
  logic             cfg_we_i;
  logic [7:0]       cfg_wdata_i;

  text_console_writer_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .char_code_i  (char_code_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cursor_pos_o (cursor_pos_o),
    .read_char_o  (read_char_o),
    .read_color_o (read_color_o),
    .scrolled_o   (scrolled_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Shadow copy of the console
  logic [15:0]     shadow_screen [CELLS];
  int unsigned     cur_x;
  int unsigned     cur_y;
  logic [7:0]      cur_color;

  console_result_t expected_results [$];
  int              mismatches = 0;
  int              burst_left = 0;
  int              heavy_budget = 110;
  int unsigned     cycle_count = 0;
  int              stall_mode = 0;
  int              stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_to(logic [7:0] v, int unsigned last);
    return (v > last) ? last : v;
  endfunction

  function automatic void fill_screen();
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = {cur_color, CH_BLANK};
  endfunction

  function automatic bit advance_line();
    if (cur_y < ROWS - 1) begin
      cur_y++;
      return 1'b0;
    end
    for (int i = 0; i < CELLS - COLUMNS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_screen[i] = {cur_color, CH_BLANK};
    return 1'b1;
  endfunction

  function automatic bit write_cell(logic [7:0] ch);
    shadow_screen[cur_y * COLUMNS + cur_x] = {cur_color, ch};
    cur_x++;
    if (cur_x >= COLUMNS) begin
      cur_x = 0;
      return advance_line();
    end
    return 1'b0;
  endfunction

  function automatic console_result_t apply_command(console_cmd_t c);
    console_result_t r;
    int unsigned     idx;
    int unsigned     lin;
    r = '0;
    case (c.cmd)
      CMD_PUT: begin
        if (c.ch == CH_CR) begin
          cur_x = 0;
        end else if (c.ch == CH_LF) begin
          cur_x = 0;
          r.scrolled = advance_line();
        end else if (c.ch == CH_TAB) begin
          for (int i = 0; i < TAB_BLANKS; i++) if (write_cell(CH_BLANK)) r.scrolled = 1'b1;
        end else begin
          r.scrolled = write_cell(c.ch);
        end
      end
      CMD_MOVE: begin
        cur_x = clamp_to(c.col, COLUMNS - 1);
        cur_y = clamp_to(c.row, ROWS - 1);
      end
      CMD_CLEAR: begin
        fill_screen();
        cur_x = 0;
        cur_y = 0;
      end
      CMD_READ: begin
        idx = clamp_to(c.row, ROWS - 1) * COLUMNS + clamp_to(c.col, COLUMNS - 1);
        r.ch = shadow_screen[idx][7:0];
        r.color = shadow_screen[idx][15:8];
      end
    endcase
    lin = cur_y * COLUMNS + cur_x;
    r.col = cur_x[X_W-1:0];
    r.row = cur_y[Y_W-1:0];
    r.pos = lin[POS_W-1:0];
    return r;
  endfunction

  function automatic console_cmd_t make_cmd(logic [1:0] cmd, logic [7:0] ch, logic [7:0] col,
                                            logic [7:0] row);
    console_cmd_t c;
    c.cmd = cmd;
    c.ch  = ch;
    c.col = col;
    c.row = row;
    return c;
  endfunction

  // Sender: bursts of random length with random gaps
  task automatic send_command(console_cmd_t c);
    int gap;
    if (burst_left == 0) burst_left = $urandom_range(1, 24);
    in_valid_i  <= 1'b1;
    cmd_i       <= c.cmd;
    char_code_i <= c.ch;
    col_i       <= c.col;
    row_i       <= c.row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(apply_command(c));
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_color(logic [7:0] color);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= color;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_color = color;
  endtask

  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int           pick;
    int unsigned  lin;
    bit           heavy;
    pick = $urandom_range(0, 99);
    c = make_cmd(CMD_PUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    if (pick < 55) begin
      c.cmd = CMD_PUT;
    end else if (pick < 63) begin
      c.ch = CH_LF;
    end else if (pick < 67) begin
      c.ch = CH_CR;
    end else if (pick < 72) begin
      c.ch = CH_TAB;
    end else if (pick < 80) begin
      c.cmd = CMD_MOVE;
      if ($urandom_range(0, 1) == 0) begin
        c.col = 8'($urandom_range(0, COLUMNS - 1));
        c.row = 8'($urandom_range(0, ROWS - 1));
      end
    end else if (pick < 81) begin
      c.cmd = CMD_CLEAR;
    end else begin
      c.cmd = CMD_READ;
      if ($urandom_range(0, 1) == 0) begin
        lin = cur_y * COLUMNS + cur_x;
        if (lin > 0) lin--;
        c.col = 8'(lin % COLUMNS);
        c.row = 8'(lin / COLUMNS);
      end
    end
    // scroll and clear sweep the whole screen store, so they are rationed
    heavy = (c.cmd == CMD_CLEAR) ||
            (c.cmd == CMD_PUT && cur_y == ROWS - 1 && c.ch != CH_CR &&
             (c.ch == CH_LF || cur_x == COLUMNS - 1 ||
              (c.ch == CH_TAB && cur_x >= COLUMNS - TAB_BLANKS)));
    if (heavy) begin
      if (heavy_budget > 0) begin
        heavy_budget--;
      end else begin
        c.cmd = CMD_MOVE;
        c.row = 8'($urandom_range(0, ROWS - 2));
      end
    end
    return c;
  endfunction

  task automatic test_reset_screen();
    send_command(make_cmd(CMD_READ, 8'd0, 8'd0, 8'd0));
    send_command(make_cmd(CMD_READ, 8'd0, 8'd255, 8'd255));
  endtask

  task automatic test_put_controls();
    send_command(make_cmd(CMD_PUT, 8'd65, 8'd0, 8'd0));
    send_command(make_cmd(CMD_PUT, 8'd0, 8'd255, 8'd255));
    send_command(make_cmd(CMD_PUT, 8'd255, 8'd0, 8'd0));
    send_command(make_cmd(CMD_PUT, CH_TAB, 8'd0, 8'd0));
    send_command(make_cmd(CMD_PUT, CH_CR, 8'd0, 8'd0));
    send_command(make_cmd(CMD_PUT, CH_LF, 8'd0, 8'd0));
    send_command(make_cmd(CMD_PUT, 8'd127, 8'd0, 8'd0));
  endtask

  task automatic test_cursor_moves();
    send_command(make_cmd(CMD_MOVE, 8'd0, 8'd255, 8'd255));
    send_command(make_cmd(CMD_MOVE, 8'd0, 8'(COLUMNS), 8'(ROWS)));
    send_command(make_cmd(CMD_MOVE, 8'd0, 8'(COLUMNS - 1), 8'd0));
    send_command(make_cmd(CMD_PUT, 8'd120, 8'd0, 8'd0));
    send_command(make_cmd(CMD_READ, 8'd0, 8'd255, 8'd0));
  endtask

  task automatic test_bottom_scroll();
    send_command(make_cmd(CMD_MOVE, 8'd0, 8'(COLUMNS - 1), 8'(ROWS - 1)));
    send_command(make_cmd(CMD_PUT, 8'd90, 8'd0, 8'd0));
    send_command(make_cmd(CMD_MOVE, 8'd0, 8'd0, 8'(ROWS - 1)));
    send_command(make_cmd(CMD_PUT, CH_LF, 8'd0, 8'd0));
    send_command(make_cmd(CMD_MOVE, 8'd0, 8'(COLUMNS - 3), 8'(ROWS - 1)));
    send_command(make_cmd(CMD_PUT, CH_TAB, 8'd0, 8'd0));
    send_command(make_cmd(CMD_READ, 8'd0, 8'd255, 8'(ROWS - 3)));
  endtask

  task automatic test_clear_colour();
    set_color(8'hFF);
    send_command(make_cmd(CMD_CLEAR, 8'd0, 8'd0, 8'd0));
    send_command(make_cmd(CMD_READ, 8'd0, 8'd200, 8'd13));
    send_command(make_cmd(CMD_PUT, 8'd113, 8'd0, 8'd0));
  endtask

  task automatic test_random_text(logic [7:0] color, int count);
    set_color(color);
    repeat (count) send_command(random_command());
  endtask

  // Result checker
  always @(posedge clk_i) begin : check_results
    console_result_t got;
    console_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {cursor_col_o, cursor_row_o, cursor_pos_o, read_char_o, read_color_o, scrolled_o};
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: col %0d row %0d pos %0d char %0d colour %0d scrolled %0d",
                   got.col, got.row, got.pos, got.ch, got.color, got.scrolled);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.col !== want.col || got.row !== want.row || got.pos !== want.pos ||
            got.ch !== want.ch || got.color !== want.color || got.scrolled !== want.scrolled) begin
          if (mismatches < 10)
            $display("mismatch: exp col %0d row %0d pos %0d char %0d colour %0d scrolled %0d, %s",
                     want.col, want.row, want.pos, want.ch, want.color, want.scrolled,
                     $sformatf("got col %0d row %0d pos %0d char %0d colour %0d scrolled %0d",
                               got.col, got.row, got.pos, got.ch, got.color, got.scrolled));
          mismatches++;
        end
      end
    end
  end

  // Receiver stall pattern
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    cmd_i       <= CMD_PUT;
    char_code_i <= 8'd0;
    col_i       <= 8'd0;
    row_i       <= 8'd0;
    out_stall_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 8'd0;
    cur_color = RESET_COLOR;
    cur_x = 0;
    cur_y = 0;
    fill_screen();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_screen();
    test_put_controls();
    test_cursor_moves();
    test_bottom_scroll();
    test_clear_colour();
    test_random_text(8'h00, 310);
    test_random_text(8'($urandom_range(1, 254)), 310);
    test_random_text(8'hFF, 310);
    test_random_text(RESET_COLOR, 310);

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
